// ===== sv/mac_keyed_timestamp_table_core_assert.svh =====
// Assertion macros for the MAC keyed timestamp table.
// Used by the port checker; depends on nothing else.
`ifndef MAC_KEYED_TIMESTAMP_TABLE_CORE_ASSERT_SVH
`define MAC_KEYED_TIMESTAMP_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MKT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mkt assertion failed");

// Next-cycle implication, disabled during reset.
`define MKT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mkt assertion failed");

`endif

// ===== sv/mkt_pkg.sv =====
// Shared types and constants for the MAC keyed timestamp table.
// No dependencies.
package mkt_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int MAC_W             = 48;
   localparam int TS_W              = 32;
   localparam int OCC_W             = 5;

   typedef enum logic [1:0] {
      CMD_UPSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_UPDATED  = 2'd0,
      ST_INSERTED = 2'd1,
      ST_FULL     = 2'd2,
      ST_DONE     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_READ_TS
   } state_type;

endpackage

// ===== sv/mkt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on mkt_pkg for default sizes.
module mkt_ram
   import mkt_pkg::*;
#(
   parameter int WIDTH = MAC_W,
   parameter int DEPTH = TABLE_ENTRIES_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mac_keyed_timestamp_table_core.sv =====
// Top level of the MAC keyed timestamp table: control, valid marks, count.
// Depends on mkt_pkg and instantiates two mkt_ram memories.
//
// A request is taken when start is high and busy is low; each request gives
// exactly one result, shown on the rsp_ ports for one cycle with rsp_strobe
// high. The receiver cannot stall, so results are never held back. MAC keys
// live in one memory and timestamps in another; an upsert or lookup walks
// the MAC memory through its single read port, one entry per cycle, and
// stops at the first valid match. A request that matches at slot k keeps
// busy high until slot k has been compared, then a lookup hit also reads
// the timestamp memory in S_READ_TS; a request that misses keeps it high
// until every slot has been compared. A lookup that hits the last slot is
// the longest case. Clear and the no-op command finish in the accept cycle
// and keep busy low; their result shows in the cycle after the accept. For
// a scanning request the result shows in the first cycle with busy low
// again. Valid marks and the entry count are flip-flops cleared at reset
// and by clear, so no memory sweep is needed.
module mac_keyed_timestamp_table_core
   import mkt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_command,
   input  logic [MAC_W-1:0]  req_mac_key,
   input  logic [TS_W-1:0]   req_seconds_in,
   input  logic [TS_W-1:0]   req_fraction_in,
   output logic              rsp_strobe,
   output logic [1:0]        rsp_status,
   output logic              rsp_found,
   output logic [TS_W-1:0]   rsp_seconds_out,
   output logic [TS_W-1:0]   rsp_fraction_out,
   output logic [OCC_W-1:0]  rsp_occupancy
);

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

   // Control state
   state_type               state_ff, state_in;
   logic [IW-1:0]           idx_ff, idx_in;          // address being read
   logic                    cmp_vld_ff, cmp_vld_in;  // read data is live
   logic [IW-1:0]           cmp_idx_ff, cmp_idx_in;  // address of live data
   logic                    free_vld_ff, free_vld_in;
   logic [IW-1:0]           free_idx_ff, free_idx_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [CW-1:0]           count_ff, count_in;

   // Request hold registers
   cmd_type                 cmd_ff, cmd_in;
   logic [MAC_W-1:0]        key_ff, key_in;
   logic [TS_W-1:0]         sec_ff, sec_in;
   logic [TS_W-1:0]         frac_ff, frac_in;

   // Result registers
   logic                    rsp_strobe_ff, rsp_strobe_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [TS_W-1:0]         rsp_sec_ff, rsp_sec_in;
   logic [TS_W-1:0]         rsp_frac_ff, rsp_frac_in;
   logic [OCC_W-1:0]        rsp_occ_ff, rsp_occ_in;

   // Memory ports
   logic                    mac_wr_en;
   logic [MAC_W-1:0]        mac_rd_data;
   logic                    ts_wr_en;
   logic [IW-1:0]           ts_wr_addr;
   logic [2*TS_W-1:0]       ts_rd_data;

   // Scan decode
   logic                    cur_valid;
   logic                    hit;
   logic                    at_last;
   logic                    free_any;
   logic [IW-1:0]           free_slot;
   logic                    accept;

   assign accept    = start && (state_ff == S_IDLE);
   assign cur_valid = valid_ff[cmp_idx_ff];
   assign hit       = cmp_vld_ff && cur_valid && (mac_rd_data == key_ff);
   assign at_last   = cmp_vld_ff && (cmp_idx_ff == LAST);
   assign free_any  = free_vld_ff || (cmp_vld_ff && !cur_valid);
   assign free_slot = free_vld_ff ? free_idx_ff : cmp_idx_ff;

   mkt_ram #(
      .WIDTH (MAC_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_mac_ram (
      .clock   (clock),
      .wr_en   (mac_wr_en),
      .wr_addr (free_slot),
      .wr_data (key_ff),
      .rd_addr (idx_ff),
      .rd_data (mac_rd_data)
   );

   mkt_ram #(
      .WIDTH (2 * TS_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ts_ram (
      .clock   (clock),
      .wr_en   (ts_wr_en),
      .wr_addr (ts_wr_addr),
      .wr_data ({sec_ff, frac_ff}),
      .rd_addr (cmp_idx_ff),
      .rd_data (ts_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cmp_vld_ff    <= 1'b0;
         free_vld_ff   <= 1'b0;
         valid_ff      <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cmp_vld_ff    <= cmp_vld_in;
         free_vld_ff   <= free_vld_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      free_idx_ff   <= free_idx_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      sec_ff        <= sec_in;
      frac_ff       <= frac_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_sec_ff    <= rsp_sec_in;
      rsp_frac_ff   <= rsp_frac_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      free_vld_in   = free_vld_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      sec_in        = sec_ff;
      frac_in       = frac_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_sec_in    = rsp_sec_ff;
      rsp_frac_in   = rsp_frac_ff;
      rsp_occ_in    = rsp_occ_ff;
      mac_wr_en     = 1'b0;
      ts_wr_en      = 1'b0;
      ts_wr_addr    = hit ? cmp_idx_ff : free_slot;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in      = cmd_type'(req_command);
               key_in      = req_mac_key;
               sec_in      = req_seconds_in;
               frac_in     = req_fraction_in;
               idx_in      = '0;
               cmp_vld_in  = 1'b0;
               free_vld_in = 1'b0;
               case (cmd_type'(req_command))
                  CMD_UPSERT, CMD_LOOKUP: begin
                     state_in = S_SCAN;
                  end
                  CMD_CLEAR: begin
                     // Drop every entry at once; memory contents stay behind
                     // invalid marks.
                     valid_in      = '0;
                     count_in      = '0;
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_DONE;
                     rsp_found_in  = 1'b0;
                     rsp_sec_in    = '0;
                     rsp_frac_in   = '0;
                     rsp_occ_in    = '0;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_DONE;
                     rsp_found_in  = 1'b0;
                     rsp_sec_in    = '0;
                     rsp_frac_in   = '0;
                     rsp_occ_in    = OCC_W'(count_ff);
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Advance the read address; hold it on the last entry.
            cmp_vld_in = 1'b1;
            cmp_idx_in = idx_ff;
            idx_in     = (idx_ff == LAST) ? idx_ff : IW'(idx_ff + 1'b1);
            // Remember the lowest free slot seen so far.
            if (!free_vld_ff && cmp_vld_ff && !cur_valid) begin
               free_vld_in = 1'b1;
               free_idx_in = cmp_idx_ff;
            end

            if (hit) begin
               if (cmd_ff == CMD_UPSERT) begin
                  ts_wr_en      = 1'b1;
                  state_in      = S_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_UPDATED;
                  rsp_found_in  = 1'b1;
                  rsp_sec_in    = sec_ff;
                  rsp_frac_in   = frac_ff;
                  rsp_occ_in    = OCC_W'(count_ff);
               end else begin
                  // Timestamp read issues at cmp_idx this cycle.
                  state_in = S_READ_TS;
               end
            end else if (at_last) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_found_in  = 1'b0;
               rsp_sec_in    = '0;
               rsp_frac_in   = '0;
               rsp_occ_in    = OCC_W'(count_ff);
               if (cmd_ff == CMD_UPSERT) begin
                  if (free_any) begin
                     mac_wr_en           = 1'b1;
                     ts_wr_en            = 1'b1;
                     valid_in[free_slot] = 1'b1;
                     count_in            = CW'(count_ff + 1'b1);
                     rsp_status_in       = ST_INSERTED;
                     rsp_occ_in          = OCC_W'(count_in);
                  end else begin
                     rsp_status_in = ST_FULL;
                  end
               end else begin
                  rsp_status_in = ST_DONE;
               end
            end
         end

         S_READ_TS: begin
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_DONE;
            rsp_found_in  = 1'b1;
            rsp_sec_in    = ts_rd_data[2*TS_W-1:TS_W];
            rsp_frac_in   = ts_rd_data[TS_W-1:0];
            rsp_occ_in    = OCC_W'(count_ff);
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_seconds_out  = rsp_sec_ff;
   assign rsp_fraction_out = rsp_frac_ff;
   assign rsp_occupancy    = rsp_occ_ff;

endmodule

// ===== sv/mkt_checker.sv =====
// Port-level checker for the MAC keyed timestamp table, bound to the top.
// Depends on mkt_pkg and mac_keyed_timestamp_table_core_assert.svh.
`include "mac_keyed_timestamp_table_core_assert.svh"

module mkt_checker
   import mkt_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic [1:0]        req_command,
   input logic [MAC_W-1:0]  req_mac_key,
   input logic [TS_W-1:0]   req_seconds_in,
   input logic [TS_W-1:0]   req_fraction_in,
   input logic              rsp_strobe,
   input logic [1:0]        rsp_status,
   input logic              rsp_found,
   input logic [TS_W-1:0]   rsp_seconds_out,
   input logic [TS_W-1:0]   rsp_fraction_out,
   input logic [OCC_W-1:0]  rsp_occupancy
);

   // A result always lands after the request has finished.
   `MKT_ASSERT_IMP(a_strobe_idle, clock, reset, rsp_strobe, !busy)

   // Clear answers in the next cycle with an empty table.
   `MKT_ASSERT_NXT(a_clear_result, clock, reset, start && !busy && req_command == CMD_CLEAR, rsp_strobe && rsp_status == ST_DONE && rsp_occupancy == '0)

   // An upsert or lookup always needs a scan.
   `MKT_ASSERT_NXT(a_scan_busy, clock, reset, start && !busy && (req_command == CMD_UPSERT || req_command == CMD_LOOKUP), busy && !rsp_strobe)

   // A miss carries a zero timestamp.
   `MKT_ASSERT_IMP(a_miss_zero, clock, reset, rsp_strobe && !rsp_found, rsp_seconds_out == '0 && rsp_fraction_out == '0)

   // Only an update or a lookup can report a match.
   `MKT_ASSERT_IMP(a_found_status, clock, reset, rsp_strobe && rsp_found, rsp_status == ST_UPDATED || rsp_status == ST_DONE)

endmodule

bind mac_keyed_timestamp_table_core mkt_checker u_mkt_checker (.*);
